// ===== sv/hfa_pkg.sv =====
// Shared types and constants for the hole fit allocator.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package hfa_pkg;

	// Table geometry
	localparam int HOLE_BITS = 6;
	localparam int HOLES     = 1 << HOLE_BITS;
	localparam int SIZE_BITS = 16;
	localparam int CNT_BITS  = HOLE_BITS + 1;

	// Configuration port
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 7;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FIT_POLICY   = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ACTIVE_HOLES = 1'd1;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_RESTORE = 2'd1,
		ACT_ALLOC   = 2'd2,
		ACT_READ    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_policy_t;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_SCAN,
		ST_UPDATE,
		ST_READ,
		ST_EMIT
	} state_t;

	// One write into a size table
	typedef struct packed {
		logic                 we;
		logic [HOLE_BITS-1:0] addr;
		logic [SIZE_BITS-1:0] data;
	} tbl_wr_t;

endpackage

`default_nettype wire

// ===== sv/hfa_if.sv =====
// Valid/ready channels for requests into and results out of the allocator.
// Depends on hfa_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hfa_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic [hfa_pkg::HOLE_BITS-1:0] hole_slot;
	logic [hfa_pkg::SIZE_BITS-1:0] size_value;

	modport source (output valid, action, hole_slot, size_value, input ready);
	modport sink   (input valid, action, hole_slot, size_value, output ready);
endinterface

interface hfa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          result_kind;
	logic                          granted;
	logic [hfa_pkg::HOLE_BITS-1:0] chosen_hole;
	logic [hfa_pkg::SIZE_BITS-1:0] remaining_size;

	modport source (output valid, result_kind, granted, chosen_hole, remaining_size,
		input ready);
	modport sink   (input valid, result_kind, granted, chosen_hole, remaining_size,
		output ready);
endinterface

`default_nettype wire

// ===== sv/hfa_store.sv =====
// Loaded and working hole size tables, one write and one registered read each.
// Depends on hfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfa_store (
	input  wire logic                          clk,
	input  wire hfa_pkg::tbl_wr_t              ld_wr,
	input  wire logic [hfa_pkg::HOLE_BITS-1:0] ld_rd_addr,
	output logic      [hfa_pkg::SIZE_BITS-1:0] ld_rd_data,
	input  wire hfa_pkg::tbl_wr_t              wk_wr,
	input  wire logic [hfa_pkg::HOLE_BITS-1:0] wk_rd_addr,
	output logic      [hfa_pkg::SIZE_BITS-1:0] wk_rd_data
);
	import hfa_pkg::*;

	logic [SIZE_BITS-1:0] loaded_mem  [HOLES];
	logic [SIZE_BITS-1:0] working_mem [HOLES];

	// Loaded sizes
	always_ff @(posedge clk) begin
		if (ld_wr.we) begin
			loaded_mem[ld_wr.addr] <= ld_wr.data;
		end
		ld_rd_data <= loaded_mem[ld_rd_addr];
	end

	// Working sizes
	always_ff @(posedge clk) begin
		if (wk_wr.we) begin
			working_mem[wk_wr.addr] <= wk_wr.data;
		end
		wk_rd_data <= working_mem[wk_rd_addr];
	end

endmodule

`default_nettype wire

// ===== sv/hole_fit_allocator_unit.sv =====
// Top level of the hole fit allocator: sequencer, scan compare unit, output register.
// Depends on hfa_pkg, hfa_if (hfa_req_if, hfa_rsp_if) and hfa_store.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    action, hole_slot, size_value
//   rsp      out  valid/ready    result_kind, granted, chosen_hole, remaining_size
//   cfg      in   cfg_wr_en      cfg_index, cfg_wdata (no read-back)
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Load writes the loaded table in the accept cycle; read passes through ST_READ and ST_EMIT.
// Allocate scans min(active_holes, 64) entries, then writes back the pick if one fits: one
// working-table read port, one entry per cycle through a single compare unit. Restore
// copies all 64 entries, one entry per cycle. A stalled result holds the sequencer in
// its last state until the output register is free. Reset clears the policy and count.
`timescale 1ns / 1ps
`default_nettype none

module hole_fit_allocator_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [hfa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [hfa_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	hfa_req_if.sink                                 req,
	hfa_rsp_if.source                               rsp
);
	import hfa_pkg::*;

	localparam logic [CNT_BITS-1:0] HOLES_CNT = CNT_BITS'(HOLES);

	state_t state_q, state_nxt;

	logic [1:0]          fit_policy_q;
	logic [CNT_BITS-1:0] active_holes_q;
	logic [CNT_BITS-1:0] scan_n;

	logic [CNT_BITS-1:0]  cnt_q;
	logic                 vld_s1;
	logic [HOLE_BITS-1:0] idx_s1;
	logic                 found_q;
	logic [HOLE_BITS-1:0] pick_q;
	logic [SIZE_BITS-1:0] best_q;
	logic [SIZE_BITS-1:0] req_size_q;
	logic [HOLE_BITS-1:0] slot_q;

	logic                 res_grant_q;
	logic                 res_kind_q;
	logic [HOLE_BITS-1:0] res_hole_q;
	logic [SIZE_BITS-1:0] res_size_q;

	logic                 out_valid_q;
	logic                 out_kind_q;
	logic                 out_grant_q;
	logic [HOLE_BITS-1:0] out_hole_q;
	logic [SIZE_BITS-1:0] out_size_q;

	logic accept;
	logic issue;
	logic emit;
	logic take;
	logic fits;

	tbl_wr_t              ld_wr, wk_wr;
	logic [HOLE_BITS-1:0] ld_rd_addr, wk_rd_addr;
	logic [SIZE_BITS-1:0] ld_rd_data, wk_rd_data;
	logic [SIZE_BITS-1:0] left_size;

	hfa_store u_store (
		.clk        (clk),
		.ld_wr      (ld_wr),
		.ld_rd_addr (ld_rd_addr),
		.ld_rd_data (ld_rd_data),
		.wk_wr      (wk_wr),
		.wk_rd_addr (wk_rd_addr),
		.wk_rd_data (wk_rd_data)
	);

	// Clamp the scan length to the table depth
	assign scan_n = (active_holes_q > HOLES_CNT) ? HOLES_CNT : active_holes_q;

	// Compare unit: does the entry fit, and does it beat the current pick
	assign fits = (wk_rd_data >= req_size_q);
	always_comb begin
		take = 1'b0;
		if (state_q == ST_SCAN && vld_s1 && fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (fit_policy_q == FIT_BEST) begin
				take = (wk_rd_data < best_q);
			end else if (fit_policy_q == FIT_WORST) begin
				take = (wk_rd_data > best_q);
			end
		end
	end

	assign left_size = best_q - req_size_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q   <= FIT_FIRST;
			active_holes_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FIT_POLICY:   fit_policy_q   <= cfg_wdata[1:0];
				CFG_ACTIVE_HOLES: active_holes_q <= cfg_wdata[CNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state, table ports and handshake
	always_comb begin
		state_nxt  = state_q;
		req.ready  = 1'b0;
		accept     = 1'b0;
		issue      = 1'b0;
		emit       = 1'b0;
		ld_wr      = '0;
		wk_wr      = '0;
		ld_rd_addr = cnt_q[HOLE_BITS-1:0];
		wk_rd_addr = cnt_q[HOLE_BITS-1:0];
		unique case (state_q)
			ST_IDLE: begin
				req.ready  = 1'b1;
				accept     = req.valid;
				wk_rd_addr = req.hole_slot;
				if (accept) begin
					unique case (action_t'(req.action))
						ACT_LOAD: begin
							ld_wr.we   = 1'b1;
							ld_wr.addr = req.hole_slot;
							ld_wr.data = req.size_value;
						end
						ACT_RESTORE: state_nxt = ST_COPY;
						ACT_ALLOC:   state_nxt = ST_SCAN;
						ACT_READ:    state_nxt = ST_READ;
						default: ;
					endcase
				end
			end
			ST_COPY: begin
				issue      = (cnt_q < HOLES_CNT);
				wk_wr.we   = vld_s1;
				wk_wr.addr = idx_s1;
				wk_wr.data = ld_rd_data;
				if (!issue && !vld_s1) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_SCAN: begin
				issue = (cnt_q < scan_n);
				if (!issue && !vld_s1) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				wk_wr.we   = found_q;
				wk_wr.addr = pick_q;
				wk_wr.data = left_size;
				state_nxt  = ST_EMIT;
			end
			ST_READ: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				emit = !out_valid_q || rsp.ready;
				if (emit) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Scan and copy control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else if (accept) begin
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	// Request fields, pick tracking and result staging
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[HOLE_BITS-1:0];
		if (accept) begin
			req_size_q <= req.size_value;
			slot_q     <= req.hole_slot;
		end
		if (take) begin
			pick_q <= idx_s1;
			best_q <= wk_rd_data;
		end
		if (state_q == ST_UPDATE) begin
			res_kind_q  <= KIND_ALLOC;
			res_grant_q <= found_q;
			res_hole_q  <= found_q ? pick_q : '0;
			res_size_q  <= found_q ? left_size : '0;
		end
		if (state_q == ST_READ) begin
			res_kind_q  <= KIND_READ;
			res_grant_q <= 1'b0;
			res_hole_q  <= slot_q;
			res_size_q  <= wk_rd_data;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q  <= res_kind_q;
			out_grant_q <= res_grant_q;
			out_hole_q  <= res_hole_q;
			out_size_q  <= res_size_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.result_kind    = out_kind_q;
	assign rsp.granted        = out_grant_q;
	assign rsp.chosen_hole    = out_hole_q;
	assign rsp.remaining_size = out_size_q;

endmodule

`default_nettype wire
